// ===== rtl/spf_pkg.sv =====
`default_nettype none

package spf_pkg;

   localparam int MAC_BYTES = 6;
   localparam int MAC_W = 48;
   localparam int HDR_LEN = MAC_BYTES + 10;
   localparam int IDX_W = $clog2(HDR_LEN + 1);
   localparam int MAC_IDX_W = (MAC_BYTES > 1) ? $clog2(MAC_BYTES) : 1;

   localparam logic [15:0] OUTER_EXTRA = 16'd8;
   localparam logic [7:0] CSUM_BASE = 8'hFF;

   localparam logic [7:0] SYNC_RESET = 8'd255;
   localparam logic [7:0] VERSION_RESET = 8'd254;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAC = 2'd2;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_PAYLOAD = 1'b1;

   localparam logic [IDX_W-1:0] POS_SYNC = IDX_W'(0);
   localparam logic [IDX_W-1:0] POS_OUTER_LO = IDX_W'(1);
   localparam logic [IDX_W-1:0] POS_OUTER_HI = IDX_W'(2);
   localparam logic [IDX_W-1:0] POS_MAC = IDX_W'(3);
   localparam logic [IDX_W-1:0] POS_SYNC2 = IDX_W'(3 + MAC_BYTES);
   localparam logic [IDX_W-1:0] POS_VERSION = IDX_W'(4 + MAC_BYTES);
   localparam logic [IDX_W-1:0] POS_LEN_LO = IDX_W'(5 + MAC_BYTES);
   localparam logic [IDX_W-1:0] POS_LEN_HI = IDX_W'(6 + MAC_BYTES);
   localparam logic [IDX_W-1:0] POS_LEN_CS = IDX_W'(7 + MAC_BYTES);
   localparam logic [IDX_W-1:0] POS_TOPIC_LO = IDX_W'(8 + MAC_BYTES);
   localparam logic [IDX_W-1:0] POS_TOPIC_HI = IDX_W'(9 + MAC_BYTES);
   localparam logic [IDX_W-1:0] POS_CLOSE = IDX_W'(HDR_LEN);
   localparam logic [IDX_W-1:0] POS_HDR_LAST = IDX_W'(HDR_LEN - 1);

   typedef struct packed {
      logic [7:0] sync_byte;
      logic [7:0] version_byte;
      logic [MAC_W-1:0] mac_addr;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic run_last;
      logic frame_end;
      logic stray;
   } rsp_type;

   function automatic logic [7:0] inv_sum(input logic [7:0] s);
      return CSUM_BASE - s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/spf_csr.sv =====
`default_nettype none

module spf_csr
   import spf_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [MAC_W-1:0] csr_wdata,
   output cfg_type cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte <= SYNC_RESET;
         cfg_ff.version_byte <= VERSION_RESET;
         cfg_ff.mac_addr <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SYNC: cfg_ff.sync_byte <= csr_wdata[7:0];
            CSR_VERSION: cfg_ff.version_byte <= csr_wdata[7:0];
            CSR_MAC: cfg_ff.mac_addr <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/spf_core.sv =====
`default_nettype none

module spf_core
   import spf_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic req_action,
   input wire logic [15:0] req_payload_len,
   input wire logic [15:0] req_topic_id,
   input wire logic [7:0] req_payload_byte,
   input wire cfg_type cfg,
   input wire logic advance,
   output logic emit_valid,
   output rsp_type emit
);

   logic item_valid_ff;
   logic action_ff;
   logic [15:0] len_ff;
   logic [15:0] topic_ff;
   logic [7:0] pb_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [15:0] bytes_left_ff;
   logic [7:0] sum_ff;
   logic open_ff;

   logic [15:0] bytes_left_in;
   logic [7:0] sum_in;
   logic open_in;

   logic [63:0] mac_wide;
   logic [7:0] mac_b [MAC_BYTES];
   logic [MAC_IDX_W-1:0] mac_sel;
   logic [15:0] outer;
   logic [7:0] topic_sum;
   logic [7:0] pay_sum;
   logic [7:0] start_byte;
   logic last;
   logic fire;
   logic load;

   assign mac_wide = {{(64 - MAC_W){1'b0}}, cfg.mac_addr};

   for (genvar i = 0; i < MAC_BYTES; i++) begin : g_mac
      assign mac_b[i] = mac_wide[8*(MAC_BYTES-1-i) +: 8];
   end

   assign mac_sel = MAC_IDX_W'(idx_ff - POS_MAC);
   assign outer = len_ff + OUTER_EXTRA;
   assign topic_sum = topic_ff[7:0] + topic_ff[15:8];
   assign pay_sum = sum_ff + pb_ff;

   always_comb begin
      case (idx_ff)
         POS_SYNC: start_byte = cfg.sync_byte;
         POS_OUTER_LO: start_byte = outer[7:0];
         POS_OUTER_HI: start_byte = outer[15:8];
         POS_SYNC2: start_byte = cfg.sync_byte;
         POS_VERSION: start_byte = cfg.version_byte;
         POS_LEN_LO: start_byte = len_ff[7:0];
         POS_LEN_HI: start_byte = len_ff[15:8];
         POS_LEN_CS: start_byte = inv_sum(len_ff[7:0] + len_ff[15:8]);
         POS_TOPIC_LO: start_byte = topic_ff[7:0];
         POS_TOPIC_HI: start_byte = topic_ff[15:8];
         POS_CLOSE: start_byte = inv_sum(topic_sum);
         default: start_byte = mac_b[mac_sel];
      endcase
   end

   always_comb begin
      if (action_ff == ACT_START) begin
         last = (len_ff == 16'd0) ? (idx_ff == POS_CLOSE) : (idx_ff == POS_HDR_LAST);
         emit.out_byte = start_byte;
         emit.frame_end = (idx_ff == POS_CLOSE);
         emit.stray = 1'b0;
      end else begin
         last = !(open_ff && bytes_left_ff == 16'd1) || (idx_ff != POS_SYNC);
         emit.out_byte = (idx_ff == POS_SYNC) ? pb_ff : inv_sum(pay_sum);
         emit.frame_end = (idx_ff != POS_SYNC);
         emit.stray = !open_ff;
      end
      emit.run_last = last;
   end

   assign emit_valid = item_valid_ff;
   assign fire = item_valid_ff && advance;
   assign req_ready = !item_valid_ff || (advance && last);
   assign load = req_valid && req_ready;

   always_comb begin
      bytes_left_in = bytes_left_ff;
      sum_in = sum_ff;
      open_in = open_ff;
      if (fire && last) begin
         if (action_ff == ACT_START) begin
            sum_in = topic_sum;
            bytes_left_in = len_ff;
            open_in = (len_ff != 16'd0);
         end else if (open_ff) begin
            sum_in = pay_sum;
            bytes_left_in = bytes_left_ff - 16'd1;
            open_in = (bytes_left_ff != 16'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         idx_ff <= '0;
         bytes_left_ff <= '0;
         sum_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         sum_ff <= sum_in;
         open_ff <= open_in;
         if (load) begin
            item_valid_ff <= 1'b1;
            idx_ff <= '0;
         end else if (fire && last) begin
            item_valid_ff <= 1'b0;
            idx_ff <= '0;
         end else if (fire) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         action_ff <= req_action;
         len_ff <= req_payload_len;
         topic_ff <= req_topic_id;
         pb_ff <= req_payload_byte;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= POS_CLOSE)
      else $error("byte index past end of header");

   a_open_count: assert property (@(posedge clock) disable iff (reset)
      open_ff == (bytes_left_ff != 16'd0))
      else $error("open frame and byte count disagree");

   a_payload_idx: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && action_ff == ACT_PAYLOAD) |-> idx_ff <= IDX_W'(1))
      else $error("payload transaction gave more than two bytes");

   a_item_holds: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !(advance && last)) |=> item_valid_ff)
      else $error("unfinished transaction dropped");

endmodule

`default_nettype wire

// ===== rtl/spf_out.sv =====
`default_nettype none

module spf_out
   import spf_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic emit_valid,
   input wire rsp_type emit,
   output logic advance,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output rsp_type rsp
);

   logic rsp_valid_ff;
   rsp_type rsp_ff;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= emit;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/serial_packet_framer.sv =====
// serial packet framer
// req channel: one transaction is either a frame start (action 0, with
// payload_len and topic_id) or one payload byte (action 1).
// rsp channel: one frame byte per transaction, with run_last on the final
// byte caused by a request, frame_end on the closing checksum and stray on
// a payload byte that arrived with no frame open.
// csr channel: index 0 sync byte, 1 version byte, 2 48-bit mac address;
// always ready, write only while the block is idle.
// a start gives MAC_BYTES+10 header bytes (16), plus the closing checksum
// when payload_len is 0; a payload byte gives one byte, two on the last
// byte of a frame. one byte leaves per cycle through the single output byte
// register while the receiver does not stall. the first rsp byte of a
// request passes through the core's request registers and then the output
// byte register. payload requests stream back to back at one per cycle
// when no checksum is due and the receiver does not stall.
// reset clears the csr registers to their defaults and closes any frame.
// when the receiver stalls the output register holds and req_ready stays
// low while a request is still held in the core.
`default_nettype none

module serial_packet_framer
   import spf_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic req_action,
   input wire logic [15:0] req_payload_len,
   input wire logic [15:0] req_topic_id,
   input wire logic [7:0] req_payload_byte,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_run_last,
   output logic rsp_frame_end,
   output logic rsp_stray,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [MAC_W-1:0] csr_wdata
);

   cfg_type cfg;
   rsp_type emit;
   rsp_type rsp;
   logic emit_valid;
   logic advance;

   spf_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg(cfg)
   );

   spf_core u_core (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_payload_len(req_payload_len),
      .req_topic_id(req_topic_id),
      .req_payload_byte(req_payload_byte),
      .cfg(cfg),
      .advance(advance),
      .emit_valid(emit_valid),
      .emit(emit)
   );

   spf_out u_out (
      .clock(clock),
      .reset(reset),
      .emit_valid(emit_valid),
      .emit(emit),
      .advance(advance),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp(rsp)
   );

   assign rsp_out_byte = rsp.out_byte;
   assign rsp_run_last = rsp.run_last;
   assign rsp_frame_end = rsp.frame_end;
   assign rsp_stray = rsp.stray;

endmodule

`default_nettype wire

// ===== verif/serial_packet_framer_tb.sv =====
module serial_packet_framer_tb;
   import spf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned ITEMS_PER_PHASE = 18;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_LONG
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = ACT_START;
   logic [15:0] req_payload_len = '0;
   logic [15:0] req_topic_id = '0;
   logic [7:0] req_payload_byte = '0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_run_last;
   logic rsp_frame_end;
   logic rsp_stray;

   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MAC_W-1:0] csr_wdata = '0;

   serial_packet_framer u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_payload_len(req_payload_len),
      .req_topic_id(req_topic_id),
      .req_payload_byte(req_payload_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last),
      .rsp_frame_end(rsp_frame_end),
      .rsp_stray(rsp_stray),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // framer state as the testbench sees it
   logic [7:0] cfg_sync = SYNC_RESET;
   logic [7:0] cfg_version = VERSION_RESET;
   logic [MAC_W-1:0] cfg_mac = '0;
   logic frame_is_open = 1'b0;
   logic [15:0] payload_remaining = '0;
   logic [7:0] topic_payload_sum = '0;

   rsp_type pending_frame_bytes[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned phase_items = 0;

   stall_mode_type stall_mode = STALL_NONE;
   logic [5:0] stall_tick = '0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      stall_tick <= stall_tick + 6'd1;
      if (stall_tick == 6'd0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
      end
      case (stall_mode)
         STALL_NONE: rsp_ready <= 1'b1;
         STALL_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
         STALL_PERIODIC: rsp_ready <= (stall_tick[1:0] != 2'd3);
         default: rsp_ready <= (stall_tick[4:0] >= 5'd18);
      endcase
   end

   always @(posedge clock) begin : check_frame_bytes
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_byte, rsp_run_last, rsp_frame_end, rsp_stray};
         if (pending_frame_bytes.size() == 0) begin
            $display("%0t: unexpected transaction: byte %h last %b end %b stray %b",
                     $time, got.out_byte, got.run_last, got.frame_end, got.stray);
            mismatch_count++;
         end else begin
            want = pending_frame_bytes.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch: expected byte %h last %b end %b stray %b, actual byte %h last %b end %b stray %b",
                        $time, want.out_byte, want.run_last, want.frame_end, want.stray,
                        got.out_byte, got.run_last, got.frame_end, got.stray);
               mismatch_count++;
            end
         end
      end
   end

   function automatic void push_frame_byte(input logic [7:0] b, input logic last,
                                           input logic fend, input logic strayed);
      pending_frame_bytes.push_back('{b, last, fend, strayed});
   endfunction

   task automatic predict_frame_bytes(input logic act, input logic [15:0] len,
                                      input logic [15:0] topic, input logic [7:0] pb);
      logic [15:0] outer;
      logic [7:0] len_sum;
      outer = len + OUTER_EXTRA;
      len_sum = len[7:0] + len[15:8];
      if (act == ACT_START) begin
         push_frame_byte(cfg_sync, 1'b0, 1'b0, 1'b0);
         push_frame_byte(outer[7:0], 1'b0, 1'b0, 1'b0);
         push_frame_byte(outer[15:8], 1'b0, 1'b0, 1'b0);
         for (int i = 0; i < MAC_BYTES; i++) begin
            push_frame_byte(cfg_mac[8*(MAC_BYTES-1-i) +: 8], 1'b0, 1'b0, 1'b0);
         end
         push_frame_byte(cfg_sync, 1'b0, 1'b0, 1'b0);
         push_frame_byte(cfg_version, 1'b0, 1'b0, 1'b0);
         push_frame_byte(len[7:0], 1'b0, 1'b0, 1'b0);
         push_frame_byte(len[15:8], 1'b0, 1'b0, 1'b0);
         push_frame_byte(~len_sum, 1'b0, 1'b0, 1'b0);
         push_frame_byte(topic[7:0], 1'b0, 1'b0, 1'b0);
         push_frame_byte(topic[15:8], len != 16'd0, 1'b0, 1'b0);
         topic_payload_sum = topic[7:0] + topic[15:8];
         if (len == 16'd0) begin
            push_frame_byte(~topic_payload_sum, 1'b1, 1'b1, 1'b0);
            frame_is_open = 1'b0;
            payload_remaining = '0;
         end else begin
            frame_is_open = 1'b1;
            payload_remaining = len;
         end
      end else if (!frame_is_open) begin
         push_frame_byte(pb, 1'b1, 1'b0, 1'b1);
      end else begin
         topic_payload_sum = topic_payload_sum + pb;
         payload_remaining = payload_remaining - 16'd1;
         if (payload_remaining == 16'd0) begin
            push_frame_byte(pb, 1'b0, 1'b0, 1'b0);
            push_frame_byte(~topic_payload_sum, 1'b1, 1'b1, 1'b0);
            frame_is_open = 1'b0;
         end else begin
            push_frame_byte(pb, 1'b1, 1'b0, 1'b0);
         end
      end
   endtask

   task automatic send_req(input logic act, input logic [15:0] len,
                           input logic [15:0] topic, input logic [7:0] pb);
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_payload_len <= len;
      req_topic_id <= topic;
      req_payload_byte <= pb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      phase_items++;
      predict_frame_bytes(act, len, topic, pb);
   endtask

   task automatic send_start(input logic [15:0] len, input logic [15:0] topic);
      send_req(ACT_START, len, topic, 8'($urandom));
   endtask

   task automatic send_payload(input logic [7:0] pb);
      send_req(ACT_PAYLOAD, 16'($urandom), 16'($urandom), pb);
   endtask

   // release the request channel and wait for every expected byte
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_frame_bytes.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [MAC_W-1:0] data,
                            input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (last) csr_valid <= 1'b0;
      case (idx)
         CSR_SYNC: cfg_sync = data[7:0];
         CSR_VERSION: cfg_version = data[7:0];
         CSR_MAC: cfg_mac = data;
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [7:0] sync, input logic [7:0] ver,
                              input logic [MAC_W-1:0] mac);
      settle();
      csr_write(CSR_SYNC, MAC_W'(sync), 1'b0);
      csr_write(CSR_VERSION, MAC_W'(ver), 1'b0);
      csr_write(CSR_MAC, mac, 1'b1);
   endtask

   task automatic test_reset_defaults();
      send_start(16'd0, 16'd0);
   endtask

   task automatic test_csr_extremes();
      load_config(8'h00, 8'h00, '0);
      send_start(16'd0, 16'hFFFF);
      load_config(8'hFF, 8'hFF, '1);
      send_start(16'd1, 16'h0000);
      send_payload(8'hFF);
      load_config(8'hA5, 8'h3C, 48'h0123_4567_89AB);
      send_start(16'd2, 16'h80FF);
      send_payload(8'h00);
      send_payload(8'h80);
   endtask

   task automatic test_unknown_index();
      settle();
      csr_write(CSR_UNUSED, MAC_W'({$urandom, $urandom}), 1'b1);
      send_start(16'd1, 16'h1234);
      send_payload(8'h5A);
   endtask

   task automatic test_stray_bytes();
      send_payload(8'h00);
      send_payload(8'hFF);
      send_start(16'd0, 16'hFEFE);
      send_payload(8'h7E);
   endtask

   task automatic test_restart();
      send_start(16'd65527, 16'hFFFF);
      send_payload(8'h11);
      send_payload(8'hEE);
      send_start(16'd2, 16'h0101);
      send_payload(8'hFF);
      send_payload(8'hFF);
   endtask

   task automatic test_outer_wrap();
      send_start(16'hFFFF, 16'h00FF);
      send_start(16'd0, 16'h0001);
   endtask

   task automatic random_phase();
      int unsigned kind;
      int unsigned nbytes;
      logic [15:0] len;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            len = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
            send_start(len, 16'($urandom));
            repeat (len) send_payload(8'($urandom));
         end else if (kind == 7) begin
            // abandoned frame, later restarted
            send_start(16'($urandom_range(0, 65527)), 16'($urandom));
            nbytes = $urandom_range(0, 3);
            repeat (nbytes) send_payload(8'($urandom));
         end else begin
            nbytes = $urandom_range(1, 3);
            repeat (nbytes) send_payload(8'($urandom));
         end
      end
   endtask

   task automatic test_random_frames();
      load_config(8'h00, 8'h00, '0);
      random_phase();
      load_config(8'hFF, 8'hFF, '1);
      random_phase();
      repeat (3) begin
         load_config(8'($urandom), 8'($urandom), MAC_W'({$urandom, $urandom}));
         random_phase();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_csr_extremes();
      test_unknown_index();
      test_stray_bytes();
      test_restart();
      test_outer_wrap();
      test_random_frames();
      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
